### design/lpbse_pkg.sv
package lpbse_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned AddrWidth     = 11;
   localparam int unsigned CountWidth    = 6;
   localparam int unsigned PixelBits     = 24;

   localparam logic [CsrIndexWidth-1:0] RegBrightness = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegDutyOne    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegDutyZero   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegResetSlots = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegPixelCount = 3'd4;

   localparam logic [7:0] BrightnessReset = 8'd0;
   localparam logic [7:0] DutyOneReset    = 8'd25;
   localparam logic [7:0] DutyZeroReset   = 8'd17;
   localparam logic [5:0] ResetSlotsReset = 6'd25;
   localparam logic [6:0] PixelCountReset = 7'd64;

   localparam logic [CountWidth-1:0] SlotsPerPixel = 6'd24;
   localparam logic [CountWidth-1:0] ResetSlotsMax = 6'd40;

   localparam int unsigned QueueDepth = 2;

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] duty_one;
      logic [7:0] duty_zero;
      logic [5:0] reset_slots;
      logic [6:0] pixel_count;
   } lpbse_cfg_type;

   // One queued job: a pixel (24 data slots) or a frame end (up to 40 zero-duty slots).
   typedef struct packed {
      logic                  frame;
      logic [AddrWidth-1:0]  base;
      logic [PixelBits-1:0]  bits;
      logic [CountWidth-1:0] count;
   } lpbse_cmd_type;

endpackage

### design/led_pixel_bit_slot_encoder.sv
// Channel  Direction  Transfer when          Carries
// req      in         req_valid & req_ready  kind, pixel_index, red, green, blue
// rsp      out        rsp_valid & rsp_ready  slot_address, duty, last
// csr      in         csr_write_enable       csr_index, csr_write_data
//
// A pixel gives 24 slot words, one per cycle while rsp is not stalled, from the
// slot counter in the back end; a frame end gives up to 40 words.
// A request goes through front stage, queue and job register to the output.
// Reset is synchronous and empties the front stage, the two-entry queue and
// the output register; the registers return to their reset values.
// A stalled rsp holds its word; the front stage and the queue keep taking
// requests until both are full.
module led_pixel_bit_slot_encoder #(
   parameter int unsigned MAX_PIXELS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [5:0]  req_pixel_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_slot_address,
   output logic [7:0]  rsp_duty,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   lpbse_pkg::lpbse_cfg_type cfg_ff, cfg_in;
   lpbse_pkg::lpbse_cmd_type f2q_cmd, q2b_cmd;
   logic                     f2q_valid, f2q_ready, q2b_valid, q2b_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lpbse_pkg::RegBrightness: cfg_in.brightness  = csr_write_data;
            lpbse_pkg::RegDutyOne:    cfg_in.duty_one    = csr_write_data;
            lpbse_pkg::RegDutyZero:   cfg_in.duty_zero   = csr_write_data;
            lpbse_pkg::RegResetSlots: cfg_in.reset_slots = csr_write_data[5:0];
            lpbse_pkg::RegPixelCount: cfg_in.pixel_count = csr_write_data[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness  <= lpbse_pkg::BrightnessReset;
         cfg_ff.duty_one    <= lpbse_pkg::DutyOneReset;
         cfg_ff.duty_zero   <= lpbse_pkg::DutyZeroReset;
         cfg_ff.reset_slots <= lpbse_pkg::ResetSlotsReset;
         cfg_ff.pixel_count <= lpbse_pkg::PixelCountReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpbse_front #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .cmd_valid       (f2q_valid),
      .cmd_ready       (f2q_ready),
      .cmd             (f2q_cmd)
   );

   lpbse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f2q_valid),
      .push_ready (f2q_ready),
      .push_data  (f2q_cmd),
      .pop_valid  (q2b_valid),
      .pop_ready  (q2b_ready),
      .pop_data   (q2b_cmd)
   );

   lpbse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_valid        (q2b_valid),
      .cmd_ready        (q2b_ready),
      .cmd              (q2b_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_address (rsp_slot_address),
      .rsp_duty         (rsp_duty),
      .rsp_last         (rsp_last)
   );

endmodule

### design/lpbse_front.sv
module lpbse_front #(
   parameter int unsigned MAX_PIXELS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpbse_pkg::lpbse_cfg_type cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [5:0]             req_pixel_index,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output lpbse_pkg::lpbse_cmd_type cmd
);

   localparam logic [8:0] MaxPix = 9'(MAX_PIXELS);

   logic                     fr_valid_ff, fr_valid_in;
   lpbse_pkg::lpbse_cmd_type fr_cmd_ff, fr_cmd_in;
   logic                     accept, keep, push;
   logic [15:0]              prod_r, prod_g, prod_b;
   logic [7:0]               scl_r, scl_g, scl_b;
   logic [8:0]               pc_wide;
   logic [6:0]               pc_sat;
   logic [11:0]              frame_base;
   logic [5:0]               n_sat;

   assign push      = fr_valid_ff && cmd_ready;
   assign req_ready = !fr_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = fr_valid_ff;
   assign cmd       = fr_cmd_ff;

   assign prod_r = req_red * cfg.brightness;
   assign prod_g = req_green * cfg.brightness;
   assign prod_b = req_blue * cfg.brightness;

   always_comb begin
      if (cfg.brightness != 8'd0) begin
         scl_r = prod_r[15:8];
         scl_g = prod_g[15:8];
         scl_b = prod_b[15:8];
      end else begin
         scl_r = req_red;
         scl_g = req_green;
         scl_b = req_blue;
      end
   end

   assign pc_wide    = {2'b00, cfg.pixel_count};
   assign pc_sat     = (pc_wide > MaxPix) ? 7'(MaxPix) : cfg.pixel_count;
   assign frame_base = {1'b0, pc_sat, 4'b0000} + {2'b00, pc_sat, 3'b000};
   assign n_sat      = (cfg.reset_slots > lpbse_pkg::ResetSlotsMax) ?
                       lpbse_pkg::ResetSlotsMax : cfg.reset_slots;

   // Pixels past the buffer and empty frame ends are taken and dropped here.
   assign keep = accept && (req_kind ? (n_sat != 6'd0)
                                     : ({3'b000, req_pixel_index} < MaxPix));

   always_comb begin
      fr_cmd_in = fr_cmd_ff;
      if (accept) begin
         fr_cmd_in.frame = req_kind;
         if (req_kind) begin
            fr_cmd_in.base  = frame_base[10:0];
            fr_cmd_in.bits  = '0;
            fr_cmd_in.count = n_sat;
         end else begin
            fr_cmd_in.base  = {1'b0, req_pixel_index, 4'b0000}
                            + {2'b00, req_pixel_index, 3'b000};
            fr_cmd_in.bits  = {scl_g, scl_r, scl_b};
            fr_cmd_in.count = lpbse_pkg::SlotsPerPixel;
         end
      end
   end

   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (keep) begin
         fr_valid_in = 1'b1;
      end else if (push) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_cmd_ff <= fr_cmd_in;
   end

   a_front_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      fr_valid_ff |-> fr_cmd_ff.count != 6'd0)
      else $error("front stage holds a job with no slots");

endmodule

### design/lpbse_queue.sv
module lpbse_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  lpbse_pkg::lpbse_cmd_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output lpbse_pkg::lpbse_cmd_type pop_data
);

   localparam int unsigned Depth    = lpbse_pkg::QueueDepth;
   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [CntWidth-1:0] Full = CntWidth'(Depth);
   localparam logic [PtrWidth-1:0] Last = PtrWidth'(Depth - 1);

   lpbse_pkg::lpbse_cmd_type mem [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != Full;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Last) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Last) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill level did not follow a lone write");

endmodule

### design/lpbse_back.sv
module lpbse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  lpbse_pkg::lpbse_cfg_type cfg,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  lpbse_pkg::lpbse_cmd_type cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [10:0]              rsp_slot_address,
   output logic [7:0]               rsp_duty,
   output logic                     rsp_last
);

   logic                     active_ff, active_in;
   lpbse_pkg::lpbse_cmd_type job_ff, job_in;
   logic [5:0]               step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [10:0]              rsp_addr_ff, rsp_addr_in;
   logic [7:0]               rsp_duty_ff, rsp_duty_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     emit, at_end, load;

   assign emit      = active_ff && (!rsp_valid_ff || rsp_ready);
   assign at_end    = step_ff == job_ff.count - 6'd1;
   assign load      = cmd_valid && (!active_ff || (emit && at_end));
   assign cmd_ready = load;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_duty         = rsp_duty_ff;
   assign rsp_last         = rsp_last_ff;

   always_comb begin
      active_in    = active_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = job_ff.base + {5'b00000, step_ff};
         rsp_last_in  = at_end;
         if (job_ff.frame) begin
            rsp_duty_in = 8'd0;
         end else begin
            rsp_duty_in = job_ff.bits[23] ? cfg.duty_one : cfg.duty_zero;
         end
         // Bits leave from the top, so the pattern shifts up one per slot.
         job_in.bits = {job_ff.bits[22:0], 1'b0};
         step_in     = step_ff + 6'd1;
         if (at_end) begin
            active_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         active_in = 1'b1;
         job_in    = cmd;
         step_in   = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      step_ff     <= step_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_back_step_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> step_ff < job_ff.count)
      else $error("slot counter ran past the job length");

   a_back_pixel_len: assert property (@(posedge clock) disable iff (reset)
      (emit && !job_ff.frame) |-> job_ff.count == lpbse_pkg::SlotsPerPixel)
      else $error("pixel job without a full set of bit slots");

   a_back_frame_duty: assert property (@(posedge clock) disable iff (reset)
      (emit && job_ff.frame) |=> rsp_valid_ff && rsp_duty_ff == 8'd0)
      else $error("frame-end slot carries a nonzero duty");

endmodule
